>>> hw/rtl/tch_pkg.sv
// Shared types, constants and helpers for the tilt-compensated heading core.
// No dependencies; the sine/cosine, level, atan2 and top-level RTL files import this package.
`default_nettype none
package tch_pkg;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ANG_W = 26;   // 2^24 units per turn plus sign and headroom
  localparam int unsigned SC_W = 33;    // Q30 sine/cosine working width
  localparam int unsigned LV_W = 52;    // level-frame vector width
  localparam int unsigned VEC_W = 55;   // arctangent working width with growth

  localparam logic signed [ANG_W-1:0] HALF_TURN = 26'sd8388608;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 26'sd4194304;
  localparam logic signed [SC_W-1:0] INV_GAIN_Q30 = 33'sd652032874;

  typedef logic signed [15:0] sample_t;

  typedef struct packed {
    sample_t mag_x;
    sample_t mag_y;
    sample_t mag_z;
    sample_t roll_angle;
    sample_t pitch_angle;
  } mag_item_t;

  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [3:0] idx);
    logic signed [ANG_W-1:0] v;
    begin
      case (idx)
        4'd0: v = 26'sd2097152;
        4'd1: v = 26'sd1238021;
        4'd2: v = 26'sd654136;
        4'd3: v = 26'sd332050;
        4'd4: v = 26'sd166669;
        4'd5: v = 26'sd83416;
        4'd6: v = 26'sd41718;
        4'd7: v = 26'sd20860;
        4'd8: v = 26'sd10430;
        4'd9: v = 26'sd5215;
        4'd10: v = 26'sd2608;
        4'd11: v = 26'sd1304;
        4'd12: v = 26'sd652;
        4'd13: v = 26'sd326;
        4'd14: v = 26'sd163;
        default: v = 26'sd81;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/tch_stream_if.sv
// Valid/ready stream interface carrying one payload of a chosen type.
// Has no dependencies; the default payload type is logic [15:0].
`default_nettype none
interface tch_stream_if #(parameter type payload_t = logic [15:0]) (input wire logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/tch_sincos.sv
// Pipelined CORDIC rotation stage array: sine and cosine in Q15 of a 16-bit angle.
// Depends on tch_pkg. One CORDIC step per register stage; advances on en.
`default_nettype none
module tch_sincos
  import tch_pkg::*;
(
  input  wire logic clk,
  input  wire logic en,
  input  wire sample_t angle,
  output logic signed [16:0] sin_q15,
  output logic signed [16:0] cos_q15
);

  logic signed [SC_W-1:0] xs [CORDIC_STEPS+1];
  logic signed [SC_W-1:0] ys [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] zs [CORDIC_STEPS+1];
  logic flips [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] z_in;

  always_comb begin
    z_in = ANG_W'(angle) <<< 8;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= INV_GAIN_Q30;
      ys[0] <= '0;
      if (z_in > QUARTER_TURN) begin
        zs[0] <= z_in - HALF_TURN;
        flips[0] <= 1'b1;
      end else if (z_in < -QUARTER_TURN) begin
        zs[0] <= z_in + HALF_TURN;
        flips[0] <= 1'b1;
      end else begin
        zs[0] <= z_in;
        flips[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        flips[i+1] <= flips[i];
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_entry(4'(i));
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_entry(4'(i));
        end
      end
    end
  end

  logic signed [SC_W-1:0] xf;
  logic signed [SC_W-1:0] yf;
  logic signed [SC_W-1:0] xr;
  logic signed [SC_W-1:0] yr;

  always_comb begin
    xf = flips[CORDIC_STEPS] ? -xs[CORDIC_STEPS] : xs[CORDIC_STEPS];
    yf = flips[CORDIC_STEPS] ? -ys[CORDIC_STEPS] : ys[CORDIC_STEPS];
    xr = (xf + SC_W'(16384)) >>> 15;
    yr = (yf + SC_W'(16384)) >>> 15;
  end

  // Near zero angle the Q30 amplitude rounds up to exactly 32768 in Q15,
  // so both outputs carry 17 signed bits.
  always_ff @(posedge clk) begin
    if (en) begin
      cos_q15 <= 17'(xr);
      sin_q15 <= 17'(yr);
    end
  end

  // zs[CORDIC_STEPS] residual is unused past the last step.
  logic unused_z;
  assign unused_z = ^zs[CORDIC_STEPS];

endmodule
`default_nettype wire

>>> hw/rtl/tch_level.sv
// Level-frame rotation: three multiplier stages forming X and -Y in Q30 scale.
// Depends on tch_pkg. Every product is registered before it is used again.
`default_nettype none
module tch_level
  import tch_pkg::*;
(
  input  wire logic clk,
  input  wire logic en,
  input  wire sample_t mx,
  input  wire sample_t my,
  input  wire sample_t mz,
  input  wire logic signed [16:0] sr,
  input  wire logic signed [16:0] cr,
  input  wire logic signed [16:0] sp,
  input  wire logic signed [16:0] cp,
  output logic signed [LV_W-1:0] xl,
  output logic signed [LV_W-1:0] yn
);

  logic signed [33:0] spsr;
  logic signed [33:0] spcr;
  logic signed [33:0] cpmx;
  logic signed [33:0] crmy;
  logic signed [33:0] srmz;
  sample_t my1;
  sample_t mz1;
  logic signed [LV_W-1:0] t_x;
  logic signed [LV_W-1:0] t_y;
  logic signed [LV_W-1:0] t_a;
  logic signed [LV_W-1:0] t_b;

  always_ff @(posedge clk) begin
    if (en) begin
      spsr <= 34'(sp * sr);
      spcr <= 34'(sp * cr);
      cpmx <= 34'(cp * 17'(mx));
      crmy <= 34'(cr * 17'(my));
      srmz <= 34'(sr * 17'(mz));
      my1 <= my;
      mz1 <= mz;
      t_a <= LV_W'(cpmx) <<< 15;
      t_x <= LV_W'(spsr) * LV_W'(my1);
      t_y <= LV_W'(spcr) * LV_W'(mz1);
      t_b <= -((LV_W'(crmy) - LV_W'(srmz)) <<< 15);
      xl <= t_a + t_x + t_y;
      yn <= t_b;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/tch_atan2.sv
// Pipelined CORDIC vectoring: atan2(y, x) rounded to a 16-bit binary angle.
// Depends on tch_pkg. One step per register stage; advances on en.
`default_nettype none
module tch_atan2
  import tch_pkg::*;
(
  input  wire logic clk,
  input  wire logic en,
  input  wire logic signed [LV_W-1:0] xv,
  input  wire logic signed [LV_W-1:0] yv,
  output sample_t heading
);

  logic signed [VEC_W-1:0] xs [CORDIC_STEPS+1];
  logic signed [VEC_W-1:0] ys [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] zs [CORDIC_STEPS+1];
  logic zero [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (xv == '0) && (yv == '0);
      if (xv < 0) begin
        xs[0] <= -VEC_W'(xv);
        ys[0] <= -VEC_W'(yv);
        zs[0] <= HALF_TURN;
      end else begin
        xs[0] <= VEC_W'(xv);
        ys[0] <= VEC_W'(yv);
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        zero[i+1] <= zero[i];
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_entry(4'(i));
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_entry(4'(i));
        end
      end
    end
  end

  logic signed [ANG_W-1:0] zr;
  always_comb begin
    zr = zs[CORDIC_STEPS] + ANG_W'(128);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      heading <= zero[CORDIC_STEPS] ? '0 : sample_t'(zr[23:8]);
    end
  end

  logic unused_v;
  assign unused_v = ^{xs[CORDIC_STEPS], ys[CORDIC_STEPS]};

endmodule
`default_nettype wire

>>> hw/rtl/tilt_compensated_heading_core.sv
// Top level of the tilt-compensated heading core: sin/cos, level rotation, atan2.
// Depends on tch_pkg, tch_stream_if, tch_sincos, tch_level and tch_atan2.
//
//  Channel   Direction  Payload
//  in_ch     sink       mag_x, mag_y, mag_z, roll_angle, pitch_angle (mag_item_t)
//  out_ch    source     heading_angle (16-bit signed binary angle)
//
// The datapath is one long pipeline: 18 sine/cosine stages, 3 multiplier stages
// and 18 arctangent stages, 39 register stages in all. One transaction can
// enter every cycle while the pipe is not stalled. The whole pipe advances
// together while its last stage is empty or the downstream side takes the
// result; a stall freezes every stage, so nothing is lost or repeated. Reset
// clears only the valid bits.
`default_nettype none
module tilt_compensated_heading_core
  import tch_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  tch_stream_if.sink in_ch,
  tch_stream_if.source out_ch
);

  // Register stages of one sine/cosine unit: input fold, the CORDIC steps, output.
  localparam int unsigned SC_LAT = CORDIC_STEPS + 2;
  localparam int unsigned DEPTH = 2 * SC_LAT + 3;

  logic [DEPTH-1:0] vld;
  logic en;
  mag_item_t item;

  // The pipe moves when its output slot is free or being emptied.
  assign en = !vld[DEPTH-1] || out_ch.ready;
  assign in_ch.ready = en;
  assign item = in_ch.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_ch.valid};
    end
  end

  // Magnetometer samples wait alongside the sine/cosine pipe.
  sample_t mx_d [SC_LAT];
  sample_t my_d [SC_LAT];
  sample_t mz_d [SC_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      mx_d[0] <= item.mag_x;
      my_d[0] <= item.mag_y;
      mz_d[0] <= item.mag_z;
      for (int i = 0; i < SC_LAT - 1; i++) begin
        mx_d[i+1] <= mx_d[i];
        my_d[i+1] <= my_d[i];
        mz_d[i+1] <= mz_d[i];
      end
    end
  end

  logic signed [16:0] sr;
  logic signed [16:0] cr;
  logic signed [16:0] sp;
  logic signed [16:0] cp;

  tch_sincos u_roll (.clk(clk), .en(en), .angle(item.roll_angle), .sin_q15(sr), .cos_q15(cr));
  tch_sincos u_pitch (.clk(clk), .en(en), .angle(item.pitch_angle), .sin_q15(sp), .cos_q15(cp));

  logic signed [LV_W-1:0] xl;
  logic signed [LV_W-1:0] yn;

  tch_level u_level (
    .clk(clk), .en(en),
    .mx(mx_d[SC_LAT-1]), .my(my_d[SC_LAT-1]), .mz(mz_d[SC_LAT-1]),
    .sr(sr), .cr(cr), .sp(sp), .cp(cp),
    .xl(xl), .yn(yn)
  );

  tch_atan2 u_atan (.clk(clk), .en(en), .xv(xl), .yv(yn), .heading(out_ch.data));

  assign out_ch.valid = vld[DEPTH-1];

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed during a stall");
  a_no_ready_full: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid)
    else $error("input blocked while output slot empty");
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline occupancy moved during a stall");

endmodule
`default_nettype wire
